[rtl/voxel_face_visibility_mask_core_defines.svh]
// assertion macros shared by the voxel face visibility checker
`ifndef VOXEL_FACE_VISIBILITY_MASK_CORE_DEFINES_SVH
`define VOXEL_FACE_VISIBILITY_MASK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define VFVM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vfvm check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define VFVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vfvm check failed");

`endif

[rtl/vfvm_pkg.sv]
// shared types and constants of the voxel face visibility core
`default_nettype none

package vfvm_pkg;

  localparam int unsigned COORD_W = 4;
  localparam int unsigned FACE_W  = 6;

  // face mask bit positions
  localparam int unsigned FACE_BACK   = 0;
  localparam int unsigned FACE_FRONT  = 1;
  localparam int unsigned FACE_LEFT   = 2;
  localparam int unsigned FACE_RIGHT  = 3;
  localparam int unsigned FACE_TOP    = 4;
  localparam int unsigned FACE_BOTTOM = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WRITE,
    ST_RD_A,
    ST_RD_B,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;     // latch the request fields
    logic clear;    // zero one row of both banks
    logic write;    // store the latched solid bit
    logic rd_b;     // second read slot: row below
    logic capture;  // keep the faces from the first read slot
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/vfvm_bank.sv]
// one bank of solid rows: bit write, row clear, two registered read ports
`default_nettype none

module vfvm_bank #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned BIT_W  = 4
) (
  input  wire logic              clk_i,
  input  wire logic              clr_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [BIT_W-1:0]  wbit_i,
  input  wire logic              wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]  rdata_a_o,
  output logic      [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_W];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      mem_q[waddr_i] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i][wbit_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[rtl/vfvm_ctrl.sv]
// sequencer for clearing, writes and the two read slots of a query
`default_nettype none

module vfvm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                opcode_i,
  input  wire vfvm_pkg::dp_status_t status_i,
  output vfvm_pkg::dp_cmd_t        cmd_o,
  output logic                     busy_o,
  output logic                     result_valid_o
);

  vfvm_pkg::ctrl_state_e state_q;
  vfvm_pkg::ctrl_state_e state_d;
  logic                  accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfvm_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // a new request may come in while the result is on the ports
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfvm_pkg::ST_CLEAR: begin
        if (status_i.clear_last) begin
          state_d = vfvm_pkg::ST_IDLE;
        end
      end
      vfvm_pkg::ST_IDLE, vfvm_pkg::ST_DONE: begin
        if (accept) begin
          state_d = (opcode_i == vfvm_pkg::OP_QUERY) ? vfvm_pkg::ST_RD_A : vfvm_pkg::ST_WRITE;
        end else begin
          state_d = vfvm_pkg::ST_IDLE;
        end
      end
      vfvm_pkg::ST_WRITE: state_d = vfvm_pkg::ST_IDLE;
      vfvm_pkg::ST_RD_A:  state_d = vfvm_pkg::ST_RD_B;
      vfvm_pkg::ST_RD_B:  state_d = vfvm_pkg::ST_DONE;
      default:            state_d = vfvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      vfvm_pkg::ST_IDLE: begin
        busy_o = 1'b0;
      end
      vfvm_pkg::ST_DONE: begin
        busy_o         = 1'b0;
        result_valid_o = 1'b1;
      end
      vfvm_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      vfvm_pkg::ST_WRITE: cmd_o.write = 1'b1;
      vfvm_pkg::ST_RD_A:  ;
      vfvm_pkg::ST_RD_B: begin
        cmd_o.rd_b    = 1'b1;
        cmd_o.capture = 1'b1;
      end
      default: ;
    endcase
    cmd_o.load = start_i && !busy_o;
  end

endmodule

`default_nettype wire

[rtl/vfvm_dp.sv]
// request registers, banked solid map, clear counter and face logic
`default_nettype none

module vfvm_dp #(
  parameter int unsigned GRID_SIDE = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire vfvm_pkg::dp_cmd_t                 cmd_i,
  output vfvm_pkg::dp_status_t                   status_o,
  input  wire logic [vfvm_pkg::COORD_W-1:0]      x_coord_i,
  input  wire logic [vfvm_pkg::COORD_W-1:0]      y_coord_i,
  input  wire logic [vfvm_pkg::COORD_W-1:0]      z_coord_i,
  input  wire logic                              solid_in_i,
  output logic      [vfvm_pkg::FACE_W-1:0]       face_mask_o,
  output logic                                   cell_solid_o,
  output logic      [vfvm_pkg::COORD_W-1:0]      x_out_o,
  output logic      [vfvm_pkg::COORD_W-1:0]      y_out_o,
  output logic      [vfvm_pkg::COORD_W-1:0]      z_out_o
);

  localparam int unsigned HalfX  = (GRID_SIDE + 1) / 2;
  localparam int unsigned XhW    = (HalfX > 1) ? $clog2(HalfX) : 1;
  localparam int unsigned YW     = $clog2(GRID_SIDE);
  localparam int unsigned ZW     = $clog2(GRID_SIDE);
  localparam int unsigned RowAw  = XhW + YW;
  localparam int unsigned NbW    = vfvm_pkg::COORD_W + 1;
  localparam logic [6:0]  SideW  = 7'(GRID_SIDE);

  logic [vfvm_pkg::COORD_W-1:0] x_q, y_q, z_q;
  logic                         solid_q;
  logic [RowAw-1:0]             clr_cnt_q;
  logic cell_q, back_q, front_q, left_q, right_q, top_q;

  logic [NbW-1:0] xp, yp, zp;
  logic [vfvm_pkg::COORD_W-1:0] xm, ym, zm;
  logic x_in, y_in, z_in, xp_in, yp_in, zp_in, xm_in, ym_in, zm_in, in_grid;
  logic [RowAw-1:0] a_cur, a_up, a_dn, a_lf, a_rt, same_a_addr, waddr;
  logic [RowAw-1:0] b0_ra, b0_rb, b1_ra, b1_rb;
  logic [GRID_SIDE-1:0] b0_a, b0_b, b1_a, b1_b;
  logic [GRID_SIDE-1:0] same_a, same_b, row_lf, row_rt;
  logic [ZW-1:0] zi, zmi, zpi;
  logic bottom;

  // rows are split by x parity, so both x neighbors sit in the other bank
  function automatic logic [RowAw-1:0] row_addr(input logic [NbW-1:0] xv,
                                                 input logic [NbW-1:0] yv);
    logic [NbW-1:0] xh;
    xh = xv >> 1;
    return {XhW'(xh), YW'(yv)};
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_coord_i;
      y_q     <= y_coord_i;
      z_q     <= z_coord_i;
      solid_q <= solid_in_i;
    end
    if (cmd_i.capture) begin
      cell_q  <= x_in && y_in && z_in && same_a[zi];
      back_q  <= !(x_in && y_in && zm_in && same_a[zmi]);
      front_q <= !(x_in && y_in && zp_in && same_a[zpi]);
      top_q   <= !(x_in && yp_in && z_in && same_b[zi]);
      left_q  <= !(xm_in && y_in && z_in && row_lf[zi]);
      right_q <= !(xp_in && y_in && z_in && row_rt[zi]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + RowAw'(1);
    end
  end

  assign status_o.clear_last = (clr_cnt_q == '1);

  assign xp = NbW'(x_q) + NbW'(1);
  assign yp = NbW'(y_q) + NbW'(1);
  assign zp = NbW'(z_q) + NbW'(1);
  assign xm = x_q - vfvm_pkg::COORD_W'(1);
  assign ym = y_q - vfvm_pkg::COORD_W'(1);
  assign zm = z_q - vfvm_pkg::COORD_W'(1);

  // a neighbor counts only when all three of its indices are on the grid
  assign x_in  = 7'(x_q) < SideW;
  assign y_in  = 7'(y_q) < SideW;
  assign z_in  = 7'(z_q) < SideW;
  assign xp_in = 7'(xp) < SideW;
  assign yp_in = 7'(yp) < SideW;
  assign zp_in = 7'(zp) < SideW;
  assign xm_in = (x_q != '0) && (7'(xm) < SideW);
  assign ym_in = (y_q != '0) && (7'(ym) < SideW);
  assign zm_in = (z_q != '0) && (7'(zm) < SideW);
  assign in_grid = x_in && y_in && z_in;

  assign zi  = ZW'(z_q);
  assign zmi = ZW'(zm);
  assign zpi = ZW'(zp);

  assign a_cur = row_addr(NbW'(x_q), NbW'(y_q));
  assign a_up  = row_addr(NbW'(x_q), yp);
  assign a_dn  = row_addr(NbW'(x_q), NbW'(ym));
  assign a_lf  = row_addr(NbW'(xm), NbW'(y_q));
  assign a_rt  = row_addr(xp, NbW'(y_q));

  assign same_a_addr = cmd_i.rd_b ? a_dn : a_cur;
  assign b0_ra = x_q[0] ? a_lf : same_a_addr;
  assign b0_rb = x_q[0] ? a_rt : a_up;
  assign b1_ra = x_q[0] ? same_a_addr : a_lf;
  assign b1_rb = x_q[0] ? a_up : a_rt;
  assign waddr = cmd_i.clear ? clr_cnt_q : a_cur;

  vfvm_bank #(
    .WIDTH  (GRID_SIDE),
    .ADDR_W (RowAw),
    .BIT_W  (ZW)
  ) u_bank_even (
    .clk_i     (clk_i),
    .clr_i     (cmd_i.clear),
    .we_i      (cmd_i.write && in_grid && !x_q[0]),
    .waddr_i   (waddr),
    .wbit_i    (zi),
    .wdata_i   (solid_q),
    .raddr_a_i (b0_ra),
    .raddr_b_i (b0_rb),
    .rdata_a_o (b0_a),
    .rdata_b_o (b0_b)
  );

  vfvm_bank #(
    .WIDTH  (GRID_SIDE),
    .ADDR_W (RowAw),
    .BIT_W  (ZW)
  ) u_bank_odd (
    .clk_i     (clk_i),
    .clr_i     (cmd_i.clear),
    .we_i      (cmd_i.write && in_grid && x_q[0]),
    .waddr_i   (waddr),
    .wbit_i    (zi),
    .wdata_i   (solid_q),
    .raddr_a_i (b1_ra),
    .raddr_b_i (b1_rb),
    .rdata_a_o (b1_a),
    .rdata_b_o (b1_b)
  );

  assign same_a = x_q[0] ? b1_a : b0_a;
  assign same_b = x_q[0] ? b1_b : b0_b;
  assign row_lf = x_q[0] ? b0_a : b1_a;
  assign row_rt = x_q[0] ? b0_b : b1_b;

  // second read slot brings the row below on port a
  assign bottom = !(x_in && ym_in && z_in && same_a[zi]);

  always_comb begin
    face_mask_o                        = '0;
    face_mask_o[vfvm_pkg::FACE_BACK]   = back_q;
    face_mask_o[vfvm_pkg::FACE_FRONT]  = front_q;
    face_mask_o[vfvm_pkg::FACE_LEFT]   = left_q;
    face_mask_o[vfvm_pkg::FACE_RIGHT]  = right_q;
    face_mask_o[vfvm_pkg::FACE_TOP]    = top_q;
    face_mask_o[vfvm_pkg::FACE_BOTTOM] = bottom;
  end

  assign cell_solid_o = cell_q;
  assign x_out_o      = x_q;
  assign y_out_o      = y_q;
  assign z_out_o      = z_q;

endmodule

`default_nettype wire

[rtl/voxel_face_visibility_mask_core.sv]
// After reset the core sweeps its solid map to zero, one row pair per cycle
// (2**(max(1, clog2(ceil(GRID_SIDE/2))) + clog2(GRID_SIDE)) row pairs, 128 at GRID_SIDE 16),
// with busy_o high. A request is taken when start_i is high and busy_o is low.
// A write keeps busy_o high for one cycle and returns nothing. A query steps
// through ST_RD_A and ST_RD_B and then puts its result on the ports with
// result_valid_o high in ST_DONE; ST_DONE already accepts the next request,
// while a write returns through ST_WRITE to ST_IDLE. A query reads the five
// rows around the cell out of two x-parity banks with two read ports each,
// in two read slots. The receiver cannot stall: a result is shown for its
// one strobe cycle only.
`default_nettype none

module voxel_face_visibility_mask_core #(
  parameter int unsigned GRID_SIDE = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         opcode_i,
  input  wire logic [vfvm_pkg::COORD_W-1:0] x_coord_i,
  input  wire logic [vfvm_pkg::COORD_W-1:0] y_coord_i,
  input  wire logic [vfvm_pkg::COORD_W-1:0] z_coord_i,
  input  wire logic                         solid_in_i,
  output logic                              result_valid_o,
  output logic      [vfvm_pkg::FACE_W-1:0]  face_mask_o,
  output logic                              cell_solid_o,
  output logic      [vfvm_pkg::COORD_W-1:0] x_out_o,
  output logic      [vfvm_pkg::COORD_W-1:0] y_out_o,
  output logic      [vfvm_pkg::COORD_W-1:0] z_out_o
);

  vfvm_pkg::dp_cmd_t    cmd;
  vfvm_pkg::dp_status_t status;

  vfvm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .opcode_i       (opcode_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  vfvm_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .z_coord_i    (z_coord_i),
    .solid_in_i   (solid_in_i),
    .face_mask_o  (face_mask_o),
    .cell_solid_o (cell_solid_o),
    .x_out_o      (x_out_o),
    .y_out_o      (y_out_o),
    .z_out_o      (z_out_o)
  );

endmodule

`default_nettype wire

[rtl/vfvm_checker.sv]
// port-level checks of request timing and result echo, bound to the core
`default_nettype none

`include "voxel_face_visibility_mask_core_defines.svh"

module vfvm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       opcode_i,
  input wire logic [3:0] x_coord_i,
  input wire logic [3:0] y_coord_i,
  input wire logic [3:0] z_coord_i,
  input wire logic       result_valid_o,
  input wire logic [3:0] x_out_o,
  input wire logic [3:0] y_out_o,
  input wire logic [3:0] z_out_o
);

  logic        query_req;
  logic        write_req;
  logic [11:0] req_xyz;
  logic [11:0] out_xyz;

  assign query_req = start_i && !busy_o && (opcode_i == vfvm_pkg::OP_QUERY);
  assign write_req = start_i && !busy_o && (opcode_i == vfvm_pkg::OP_WRITE);
  assign req_xyz   = {x_coord_i, y_coord_i, z_coord_i};
  assign out_xyz   = {x_out_o, y_out_o, z_out_o};

  `VFVM_ASSERT_SAME(a_no_result_while_busy, result_valid_o, !busy_o)
  `VFVM_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o)
  `VFVM_ASSERT_SAME(a_query_latency, query_req, ##3 result_valid_o)
  `VFVM_ASSERT_NEXT(a_write_silent, write_req, !result_valid_o ##1 !result_valid_o)
  `VFVM_ASSERT_SAME(a_echo_coords, query_req, ##3 (out_xyz == $past(req_xyz, 3)))

endmodule

bind voxel_face_visibility_mask_core vfvm_checker u_vfvm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .opcode_i       (opcode_i),
  .x_coord_i      (x_coord_i),
  .y_coord_i      (y_coord_i),
  .z_coord_i      (z_coord_i),
  .result_valid_o (result_valid_o),
  .x_out_o        (x_out_o),
  .y_out_o        (y_out_o),
  .z_out_o        (z_out_o)
);

`default_nettype wire

[verif/tb.sv]
// testbench for the voxel face visibility core: directed and random requests against a scoreboard
`timescale 1ns / 1ps

module tb;

  localparam int GRID_SIDE  = 16;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ITEMS      = 1750;
  localparam int PHASES     = 5;
  localparam int MAX_PRINTS = 20;
  localparam int COORD_W    = vfvm_pkg::COORD_W;
  localparam int FACE_W     = vfvm_pkg::FACE_W;

  typedef struct packed {
    logic [FACE_W-1:0]  face_mask;
    logic               cell_solid;
    logic [COORD_W-1:0] x_out;
    logic [COORD_W-1:0] y_out;
    logic [COORD_W-1:0] z_out;
  } face_result_t;

  class face_scoreboard;
    bit           solid_cells [CELL_COUNT];
    face_result_t pending_faces [$];
    int           errors;
    int           writes;
    int           queries;
    int           checked;
    int           solid_hits;
    int           hidden_hits;

    function bit solid_at(int x, int y, int z);
      if (x < 0 || x >= GRID_SIDE || y < 0 || y >= GRID_SIDE || z < 0 || z >= GRID_SIDE)
        return 1'b0;
      return solid_cells[(x * GRID_SIDE + y) * GRID_SIDE + z];
    endfunction

    function face_result_t compute_faces(int x, int y, int z);
      face_result_t r;
      r.face_mask                        = '0;
      r.face_mask[vfvm_pkg::FACE_BACK]   = !solid_at(x, y, z - 1);
      r.face_mask[vfvm_pkg::FACE_FRONT]  = !solid_at(x, y, z + 1);
      r.face_mask[vfvm_pkg::FACE_LEFT]   = !solid_at(x - 1, y, z);
      r.face_mask[vfvm_pkg::FACE_RIGHT]  = !solid_at(x + 1, y, z);
      r.face_mask[vfvm_pkg::FACE_TOP]    = !solid_at(x, y + 1, z);
      r.face_mask[vfvm_pkg::FACE_BOTTOM] = !solid_at(x, y - 1, z);
      r.cell_solid                       = solid_at(x, y, z);
      r.x_out                            = COORD_W'(x);
      r.y_out                            = COORD_W'(y);
      r.z_out                            = COORD_W'(z);
      return r;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch: %s", what);
    endtask

    function void note_request(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [COORD_W-1:0] z, logic solid);
      int xi;
      int yi;
      int zi;
      xi = int'(x);
      yi = int'(y);
      zi = int'(z);
      if (op == vfvm_pkg::OP_WRITE) begin
        // coordinates are 4 bits wide, so every write lands inside a grid of 16 cells per side
        if (xi < GRID_SIDE && yi < GRID_SIDE && zi < GRID_SIDE)
          solid_cells[(xi * GRID_SIDE + yi) * GRID_SIDE + zi] = solid;
        writes++;
      end else begin
        pending_faces.insert(pending_faces.size(), compute_faces(xi, yi, zi));
        queries++;
      end
    endfunction

    task check_result(face_result_t got);
      face_result_t exp_r;
      if (pending_faces.size() == 0) begin
        report_mismatch($sformatf("result (%0d,%0d,%0d) with no query waiting",
                                  got.x_out, got.y_out, got.z_out));
        return;
      end
      exp_r = pending_faces.pop_front();
      checked++;
      if (exp_r.cell_solid) solid_hits++;
      if (exp_r.face_mask == '0) hidden_hits++;
      if (got.face_mask !== exp_r.face_mask)
        report_mismatch($sformatf("face_mask at (%0d,%0d,%0d): got %b, want %b",
                                  exp_r.x_out, exp_r.y_out, exp_r.z_out,
                                  got.face_mask, exp_r.face_mask));
      if (got.cell_solid !== exp_r.cell_solid)
        report_mismatch($sformatf("cell_solid at (%0d,%0d,%0d): got %b, want %b",
                                  exp_r.x_out, exp_r.y_out, exp_r.z_out,
                                  got.cell_solid, exp_r.cell_solid));
      if (got.x_out !== exp_r.x_out)
        report_mismatch($sformatf("x_out: got %0d, want %0d", got.x_out, exp_r.x_out));
      if (got.y_out !== exp_r.y_out)
        report_mismatch($sformatf("y_out: got %0d, want %0d", got.y_out, exp_r.y_out));
      if (got.z_out !== exp_r.z_out)
        report_mismatch($sformatf("z_out: got %0d, want %0d", got.z_out, exp_r.z_out));
    endtask

    function int pending();
      return pending_faces.size();
    endfunction
  endclass

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start_i    = 1'b0;
  logic               opcode_i   = vfvm_pkg::OP_WRITE;
  logic [COORD_W-1:0] x_coord_i  = '0;
  logic [COORD_W-1:0] y_coord_i  = '0;
  logic [COORD_W-1:0] z_coord_i  = '0;
  logic               solid_in_i = 1'b0;
  logic               busy_o;
  logic               result_valid_o;
  logic [FACE_W-1:0]  face_mask_o;
  logic               cell_solid_o;
  logic [COORD_W-1:0] x_out_o;
  logic [COORD_W-1:0] y_out_o;
  logic [COORD_W-1:0] z_out_o;

  face_scoreboard sb = new();

  int cluster_x;
  int cluster_y;
  int cluster_z;

  voxel_face_visibility_mask_core #(
    .GRID_SIDE(GRID_SIDE)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .z_coord_i     (z_coord_i),
    .solid_in_i    (solid_in_i),
    .result_valid_o(result_valid_o),
    .face_mask_o   (face_mask_o),
    .cell_solid_o  (cell_solid_o),
    .x_out_o       (x_out_o),
    .y_out_o       (y_out_o),
    .z_out_o       (z_out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result check first, then the request taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o === 1'b1)
        sb.check_result({face_mask_o, cell_solid_o, x_out_o, y_out_o, z_out_o});
      if (start_i && busy_o === 1'b0)
        sb.note_request(opcode_i, x_coord_i, y_coord_i, z_coord_i, solid_in_i);
    end
  end

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(logic op, int x, int y, int z, logic solid);
    start_i    <= 1'b1;
    opcode_i   <= op;
    x_coord_i  <= COORD_W'(x);
    y_coord_i  <= COORD_W'(y);
    z_coord_i  <= COORD_W'(z);
    solid_in_i <= solid;
    #0;
    while (busy_o !== 1'b0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    start_i    <= 1'b0;
    opcode_i   <= 1'($urandom);
    x_coord_i  <= COORD_W'($urandom);
    y_coord_i  <= COORD_W'($urandom);
    z_coord_i  <= COORD_W'($urandom);
    solid_in_i <= 1'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // edges of the grid, a small cluster so neighbours meet, or anywhere
  function automatic int pick_coord(int base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return GRID_SIDE - 1;
    if (r < 75) return base + $urandom_range(0, 3);
    return $urandom_range(0, GRID_SIDE - 1);
  endfunction

  task automatic random_phase(int count, int idle_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        cluster_x = $urandom_range(0, GRID_SIDE - 4);
        cluster_y = $urandom_range(0, GRID_SIDE - 4);
        cluster_z = $urandom_range(0, GRID_SIDE - 4);
      end
      if ($urandom_range(1, 100) <= idle_pct) idle_cycles($urandom_range(1, 4));
      op = ($urandom_range(0, 99) < 45) ? vfvm_pkg::OP_WRITE : vfvm_pkg::OP_QUERY;
      send_request(op, pick_coord(cluster_x), pick_coord(cluster_y), pick_coord(cluster_z),
                   ($urandom_range(0, 99) < 70));
    end
  endtask

  initial begin
    int idle_pct [PHASES];
    idle_pct = '{0, 69, 0, 9, 69};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty grid: everything exposed, solid_in ignored on a query
    send_request(vfvm_pkg::OP_QUERY, 0, 0, 0, 1'b1);
    send_request(vfvm_pkg::OP_QUERY, 15, 15, 15, 1'b0);
    send_request(vfvm_pkg::OP_WRITE, 15, 15, 15, 1'b1);
    send_request(vfvm_pkg::OP_QUERY, 15, 15, 15, 1'b0);
    // fully enclosed cell
    send_request(vfvm_pkg::OP_WRITE, 7, 8, 9, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 7, 8, 8, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 7, 8, 10, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 6, 8, 9, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 8, 8, 9, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 7, 9, 9, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 7, 7, 9, 1'b1);
    send_request(vfvm_pkg::OP_QUERY, 7, 8, 9, 1'b0);
    // clearing one neighbour opens its face, empty cell still answered
    send_request(vfvm_pkg::OP_WRITE, 7, 8, 10, 1'b0);
    send_request(vfvm_pkg::OP_QUERY, 7, 8, 9, 1'b1);
    send_request(vfvm_pkg::OP_QUERY, 7, 8, 10, 1'b0);
    // corner: outside neighbours stay exposed
    send_request(vfvm_pkg::OP_WRITE, 0, 0, 0, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 1, 0, 0, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 0, 1, 0, 1'b1);
    send_request(vfvm_pkg::OP_WRITE, 0, 0, 1, 1'b1);
    send_request(vfvm_pkg::OP_QUERY, 0, 0, 0, 1'b0);
    send_request(vfvm_pkg::OP_QUERY, 1, 0, 0, 1'b0);
    send_request(vfvm_pkg::OP_QUERY, 8, 15, 0, 1'b1);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      random_phase(ITEMS / PHASES, idle_pct[p]);
      drain_results();
    end
    repeat (8) @(negedge clk_i);

    $display("covered %0d writes and %0d queries over %0d idle phases",
             sb.writes, sb.queries, PHASES);
    $display("checked %0d face masks, %0d on solid cells, %0d fully hidden",
             sb.checked, sb.solid_hits, sb.hidden_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      if (sb.pending() != 0) $display("%0d queries never answered", sb.pending());
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d queries waiting", sb.pending());
    $display("tb failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/vfvm_pkg.sv
rtl/vfvm_bank.sv
rtl/vfvm_ctrl.sv
rtl/vfvm_dp.sv
rtl/voxel_face_visibility_mask_core.sv
rtl/vfvm_checker.sv
verif/tb.sv
